// ===== src/timing_table_interpolator_assert.svh =====
// Assertion macros for the timing table interpolator.
// Used by the top level; no other dependencies.
`ifndef TIMING_TABLE_INTERPOLATOR_ASSERT_SVH
`define TIMING_TABLE_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTH
`define TTI_ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("timing table assertion failed");
`define TTI_ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("timing table assertion failed");
`else
`define TTI_ASSERT_IMP(name, clk, rst_n, pre, post)
`define TTI_ASSERT_NXT(name, clk, rst_n, pre, post)
`endif
`endif

// ===== src/tti_pkg.sv =====
// Shared types and constants of the timing table interpolator.
// No dependencies.
`default_nettype none
package tti_pkg;
  localparam int SIZE_W = 32;
  localparam int TIME_W = 63;
  localparam int PROD_W = SIZE_W + TIME_W;
  localparam int DC_W   = $clog2(PROD_W);
  localparam int HALF_W = 32;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic ACT_RECORD = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_FOUND   = 2'd1,
    ST_UNSUPPORTED = 2'd2,
    ST_FULL        = 2'd3
  } tti_status_t;

  typedef enum logic [2:0] {
    DEC_L_NF     = 3'd0,
    DEC_L_MARK   = 3'd1,
    DEC_L_DIRECT = 3'd2,
    DEC_L_INTERP = 3'd3,
    DEC_U_MARK   = 3'd4,
    DEC_U_AVG    = 3'd5,
    DEC_U_FULL   = 3'd6,
    DEC_U_INS    = 3'd7
  } tti_dec_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic addr;
    logic cnt_lat;
    logic scan;
    logic sel;
    logic prep;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div;
    logic fin;
    logic mark_wr;
    logic avg_wr;
    logic sh_rd;
    logic sh_wr;
    logic ins_wr;
    logic out_ld;
  } tti_cmd_t;

  typedef struct packed {
    logic     clr_done;
    logic     range_bad;
    logic     scan_done;
    tti_dec_t dec;
    logic     div_done;
    logic     sh_more;
    logic     out_free;
  } tti_sts_t;
endpackage
`default_nettype wire

// ===== src/tti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tti_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/tti_ctrl.sv =====
// Controller state machine of the timing table interpolator.
// Depends on tti_pkg for the command and status structs.
`default_nettype none
module tti_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tti_pkg::tti_sts_t sts,
  output tti_pkg::tti_cmd_t cmd,
  output logic              idle
);
  import tti_pkg::*;

  typedef enum logic [18:0] {
    S_CLEAR = 19'b1 << 0,
    S_IDLE  = 19'b1 << 1,
    S_ADDR  = 19'b1 << 2,
    S_CNTW  = 19'b1 << 3,
    S_CNTL  = 19'b1 << 4,
    S_SCAN  = 19'b1 << 5,
    S_SEL   = 19'b1 << 6,
    S_PREP  = 19'b1 << 7,
    S_MUL1  = 19'b1 << 8,
    S_MUL2  = 19'b1 << 9,
    S_MUL3  = 19'b1 << 10,
    S_DIV   = 19'b1 << 11,
    S_FIN   = 19'b1 << 12,
    S_MARK  = 19'b1 << 13,
    S_AVG   = 19'b1 << 14,
    S_SHR   = 19'b1 << 15,
    S_SHW   = 19'b1 << 16,
    S_INS   = 19'b1 << 17,
    S_OUT   = 19'b1 << 18
  } state_t;

  state_t state_r, state_nxt;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = sts.range_bad ? S_OUT : S_CNTW;
      end
      S_CNTW: state_nxt = S_CNTL;
      S_CNTL: begin
        cmd.cnt_lat = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel = 1'b1;
        unique case (sts.dec)
          DEC_L_INTERP: state_nxt = S_PREP;
          DEC_U_MARK:   state_nxt = S_MARK;
          DEC_U_AVG:    state_nxt = S_AVG;
          DEC_U_INS:    state_nxt = S_SHR;
          default:      state_nxt = S_OUT;
        endcase
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_OUT;
      end
      S_MARK: begin
        cmd.mark_wr = 1'b1;
        state_nxt   = S_OUT;
      end
      S_AVG: begin
        cmd.avg_wr = 1'b1;
        state_nxt  = S_OUT;
      end
      S_SHR: begin
        // move entries up one place, top first, to open the insert position
        if (sts.sh_more) begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHW;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_SHW: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHR;
      end
      S_INS: begin
        cmd.ins_wr = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/tti_dp.sv =====
// Datapath of the timing table interpolator: table memories, scan,
// multiplier, bit-serial divider and result register.
// Depends on tti_pkg and tti_ram.
`default_nettype none
module tti_dp #(
  parameter int BACKENDS         = 4,
  parameter int OPERATIONS       = 64,
  parameter int ENTRIES_PER_SLOT = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tti_pkg::tti_cmd_t          cmd,
  output tti_pkg::tti_sts_t          sts,
  input  logic                       action,
  input  logic [1:0]                 backend_id,
  input  logic [5:0]                 operation_id,
  input  logic                       quantized,
  input  logic [tti_pkg::SIZE_W-1:0] operand_size,
  input  logic [tti_pkg::TIME_W-1:0] measured_time,
  input  logic                       out_stall,
  output logic                       out_valid,
  output tti_pkg::tti_status_t       out_status,
  output logic [tti_pkg::TIME_W-1:0] out_time
);
  import tti_pkg::*;

  localparam int SLOTS   = BACKENDS * OPERATIONS * 2;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int ENTRIES = SLOTS * ENTRIES_PER_SLOT;
  localparam int AW      = $clog2(ENTRIES);
  localparam int IDX_W   = $clog2(ENTRIES_PER_SLOT + 1);
  localparam int ENT_W   = SIZE_W + TIME_W;
  localparam logic [IDX_W-1:0] EPS_N = IDX_W'(ENTRIES_PER_SLOT);

  // item
  logic              act_r, qn_r;
  logic [1:0]        be_r;
  logic [5:0]        op_r;
  logic [SIZE_W-1:0] size_r;
  logic [TIME_W-1:0] tm_r;
  logic [SLOT_W-1:0] slot_r, clr_idx_r;
  logic [AW-1:0]     base;

  // scan
  logic [IDX_W-1:0]  n_r, ridx_r, pi_r, pos_r, sidx_r;
  logic              pv_r, found_r, exact_r, marked_r;
  logic [SIZE_W-1:0] lo_s_r, hi_s_r, e0_s_r, e1_s_r, l1_s_r, l2_s_r;
  logic [TIME_W-1:0] lo_t_r, hi_t_r, e0_t_r, e1_t_r, l1_t_r, l2_t_r;

  // interpolation
  logic [SIZE_W-1:0] x0_r, x1_r, dx_r, d_r, rem_r;
  logic [TIME_W-1:0] y0_r, y1_r, dy_r;
  logic              neg_r, gt_r, degen_r;
  logic [63:0]       pp_r;
  logic [PROD_W-1:0] prod_r;
  logic [DC_W-1:0]   div_cnt_r;

  tti_status_t       stat_r;
  logic [TIME_W-1:0] res_r;
  logic              out_valid_r;
  tti_status_t       out_status_r;
  logic [TIME_W-1:0] out_time_r;

  // memories
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_waddr;
  logic [IDX_W-1:0]  cnt_wdata, cnt_rdata;
  logic              ent_we;
  logic [AW-1:0]     ent_waddr, ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic [SIZE_W-1:0] cur_s;
  logic [TIME_W-1:0] cur_t;

  tti_ram #(.W(IDX_W), .D(SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (slot_r),
    .rdata (cnt_rdata)
  );

  tti_ram #(.W(ENT_W), .D(ENTRIES)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign base  = AW'(slot_r) * AW'(ENTRIES_PER_SLOT);
  assign cur_s = ent_rdata[ENT_W-1:TIME_W];
  assign cur_t = ent_rdata[TIME_W-1:0];

  always_comb begin
    cnt_we    = cmd.clr_wr | cmd.mark_wr | cmd.ins_wr;
    cnt_waddr = slot_r;
    cnt_wdata = n_r + IDX_W'(1);
    priority if (cmd.clr_wr) begin
      cnt_waddr = clr_idx_r;
      cnt_wdata = '0;
    end else if (cmd.mark_wr) begin
      cnt_wdata = IDX_W'(1);
    end
  end

  logic [TIME_W:0] avg_sum;
  assign avg_sum = {1'b0, hi_t_r} + {1'b0, tm_r};

  always_comb begin
    ent_we    = cmd.mark_wr | cmd.avg_wr | cmd.sh_wr | cmd.ins_wr;
    ent_waddr = base + AW'(pos_r);
    ent_wdata = {size_r, tm_r};
    priority if (cmd.mark_wr) begin
      ent_waddr = base;
      ent_wdata = {size_r, TIME_MAX};
    end else if (cmd.avg_wr) begin
      ent_wdata = {size_r, avg_sum[TIME_W:1]};
    end else if (cmd.sh_wr) begin
      ent_waddr = base + AW'(sidx_r);
      ent_wdata = ent_rdata;
    end
    ent_raddr = cmd.sh_rd ? base + AW'(sidx_r - IDX_W'(1)) : base + AW'(ridx_r);
  end

  // decision after the scan
  logic exact;
  assign exact = found_r & exact_r;

  always_comb begin
    if (act_r == ACT_RECORD) begin
      priority if (tm_r == TIME_MAX || marked_r) sts.dec = DEC_U_MARK;
      else if (exact)                            sts.dec = DEC_U_AVG;
      else if (n_r >= EPS_N)                     sts.dec = DEC_U_FULL;
      else                                       sts.dec = DEC_U_INS;
    end else begin
      priority if (n_r == '0)                    sts.dec = DEC_L_NF;
      else if (marked_r)                         sts.dec = DEC_L_MARK;
      else if (exact || n_r == IDX_W'(1))        sts.dec = DEC_L_DIRECT;
      else                                       sts.dec = DEC_L_INTERP;
    end
  end

  assign sts.clr_done  = (clr_idx_r == SLOT_W'(SLOTS - 1));
  assign sts.range_bad = (int'(be_r) >= BACKENDS) || (int'(op_r) >= OPERATIONS);
  assign sts.scan_done = !pv_r && (ridx_r == n_r);
  assign sts.div_done  = (div_cnt_r == DC_W'(PROD_W - 1));
  assign sts.sh_more   = (sidx_r > pos_r);
  assign sts.out_free  = !out_valid_r || !out_stall;

  // operand preparation
  logic              dx_neg, dy_neg;
  logic [SIZE_W-1:0] dx;
  logic [TIME_W-1:0] dy;
  assign dx_neg = size_r < x0_r;
  assign dy_neg = y1_r < y0_r;
  assign dx     = dx_neg ? x0_r - size_r : size_r - x0_r;
  assign dy     = dy_neg ? y0_r - y1_r : y1_r - y0_r;

  // divider step
  logic [SIZE_W:0] rem_t;
  logic            ge;
  assign rem_t = {rem_r, prod_r[PROD_W-1]};
  assign ge    = rem_t >= {1'b0, d_r};

  // final result of an interpolation
  logic [TIME_W-1:0] q, fin_val, diff, sum;
  logic              big;
  assign q    = prod_r[TIME_W-1:0];
  assign big  = |prod_r[PROD_W-1:TIME_W];
  assign diff = y0_r - q;
  assign sum  = y0_r + q;

  always_comb begin
    priority if (degen_r) begin
      fin_val = (y0_r == '0) ? TIME_W'(1) : y0_r;
    end else if (neg_r) begin
      if (big || q > y0_r) fin_val = gt_r ? y0_r : TIME_W'(1);
      else                 fin_val = (diff == '0) ? TIME_W'(1) : diff;
    end else begin
      if (big || q > TIME_MAX - y0_r) fin_val = TIME_MAX;
      else                            fin_val = (sum == '0) ? TIME_W'(1) : sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_idx_r <= clr_idx_r + SLOT_W'(1);
      if (cmd.cnt_lat) begin
        pv_r <= 1'b0;
      end else if (cmd.scan) begin
        pv_r <= (ridx_r < n_r);
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action;
      be_r   <= backend_id;
      op_r   <= operation_id;
      qn_r   <= quantized;
      size_r <= operand_size;
      tm_r   <= measured_time;
      stat_r <= ST_NOT_FOUND;
      res_r  <= '0;
    end
    if (cmd.addr) begin
      slot_r <= SLOT_W'((int'(be_r) * OPERATIONS + int'(op_r)) * 2 + int'(qn_r));
    end
    if (cmd.cnt_lat) begin
      n_r      <= (cnt_rdata > EPS_N) ? EPS_N : cnt_rdata;
      pos_r    <= (cnt_rdata > EPS_N) ? EPS_N : cnt_rdata;
      ridx_r   <= '0;
      found_r  <= 1'b0;
      exact_r  <= 1'b0;
      marked_r <= 1'b0;
    end
    if (cmd.scan) begin
      if (ridx_r < n_r) begin
        pi_r   <= ridx_r;
        ridx_r <= ridx_r + IDX_W'(1);
      end
      if (pv_r) begin
        if (cur_t == TIME_MAX) marked_r <= 1'b1;
        // first entry not below the size brackets it from above
        if (!found_r && cur_s >= size_r) begin
          found_r <= 1'b1;
          pos_r   <= pi_r;
          exact_r <= (cur_s == size_r);
          lo_s_r  <= l1_s_r;
          lo_t_r  <= l1_t_r;
          hi_s_r  <= cur_s;
          hi_t_r  <= cur_t;
        end
        if (pi_r == '0) begin
          e0_s_r <= cur_s;
          e0_t_r <= cur_t;
        end
        if (pi_r == IDX_W'(1)) begin
          e1_s_r <= cur_s;
          e1_t_r <= cur_t;
        end
        l2_s_r <= l1_s_r;
        l2_t_r <= l1_t_r;
        l1_s_r <= cur_s;
        l1_t_r <= cur_t;
      end
    end
    if (cmd.sel) begin
      sidx_r <= n_r;
      unique case (sts.dec)
        DEC_L_MARK: begin
          stat_r <= ST_UNSUPPORTED;
          res_r  <= TIME_MAX;
        end
        DEC_L_DIRECT: begin
          stat_r <= ST_OK;
          res_r  <= exact ? hi_t_r : e0_t_r;
        end
        DEC_L_INTERP: stat_r <= ST_OK;
        DEC_U_MARK:   stat_r <= ST_UNSUPPORTED;
        DEC_U_AVG:    stat_r <= ST_OK;
        DEC_U_INS:    stat_r <= ST_OK;
        DEC_U_FULL:   stat_r <= ST_FULL;
        default:      stat_r <= ST_NOT_FOUND;
      endcase
      priority if (pos_r == n_r) begin
        x0_r <= l2_s_r;
        y0_r <= l2_t_r;
        x1_r <= l1_s_r;
        y1_r <= l1_t_r;
      end else if (pos_r == '0) begin
        x0_r <= e0_s_r;
        y0_r <= e0_t_r;
        x1_r <= e1_s_r;
        y1_r <= e1_t_r;
      end else begin
        x0_r <= lo_s_r;
        y0_r <= lo_t_r;
        x1_r <= hi_s_r;
        y1_r <= hi_t_r;
      end
    end
    if (cmd.sh_wr) sidx_r <= sidx_r - IDX_W'(1);
    if (cmd.prep) begin
      dx_r      <= dx;
      dy_r      <= dy;
      d_r       <= x1_r - x0_r;
      degen_r   <= (x1_r <= x0_r);
      neg_r     <= (dx_neg != dy_neg) && (dx != '0) && (dy != '0);
      gt_r      <= (size_r > x1_r);
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.mul1) pp_r <= dx_r * dy_r[HALF_W-1:0];
    if (cmd.mul2) begin
      prod_r <= PROD_W'(pp_r);
      pp_r   <= dx_r * {1'b0, dy_r[TIME_W-1:HALF_W]};
    end
    if (cmd.mul3) prod_r <= prod_r + {pp_r[TIME_W-1:0], {HALF_W{1'b0}}};
    if (cmd.div) begin
      // restoring division, quotient bits shift in behind the dividend
      rem_r     <= ge ? SIZE_W'(rem_t - {1'b0, d_r}) : rem_t[SIZE_W-1:0];
      prod_r    <= {prod_r[PROD_W-2:0], ge};
      div_cnt_r <= div_cnt_r + DC_W'(1);
    end
    if (cmd.fin) res_r <= fin_val;
    if (cmd.out_ld) begin
      out_status_r <= stat_r;
      out_time_r   <= res_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_time   = out_time_r;
endmodule
`default_nettype wire

// ===== src/timing_table_interpolator.sv =====
// Timing table interpolator: measured-time table with linear interpolation.
// After reset a clearing pass empties every slot, one slot per cycle
// (BACKENDS*OPERATIONS*2 slots, 512 by default), and no item is accepted
// until it ends. Items are then handled one at a time. The time of an
// update or a direct lookup is set by the entry scan through the single
// read port of the entry memory; an insert then moves each entry at or
// above the insert position up one place by a read and a write. An
// interpolating lookup adds a multiply from 32x32 partial products in the
// states MUL1, MUL2 and MUL3 and a bit-serial divider over the 95 bits of
// the product. Results sit in an output register, so a new item is taken while the last result waits.
`default_nettype none
`include "timing_table_interpolator_assert.svh"
module timing_table_interpolator #(
  parameter int BACKENDS         = 4,
  parameter int OPERATIONS       = 64,
  parameter int ENTRIES_PER_SLOT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [1:0]  in_backend_id,
  input  logic [5:0]  in_operation_id,
  input  logic        in_quantized,
  input  logic [31:0] in_operand_size,
  input  logic [62:0] in_measured_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [62:0] out_result_time
);
  import tti_pkg::*;

  tti_cmd_t    cmd;
  tti_sts_t    sts;
  tti_status_t status;
  logic        idle;

  tti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  tti_dp #(
    .BACKENDS         (BACKENDS),
    .OPERATIONS       (OPERATIONS),
    .ENTRIES_PER_SLOT (ENTRIES_PER_SLOT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .action        (in_action),
    .backend_id    (in_backend_id),
    .operation_id  (in_operation_id),
    .quantized     (in_quantized),
    .operand_size  (in_operand_size),
    .measured_time (in_measured_time),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_status    (status),
    .out_time      (out_result_time)
  );

  assign in_stall   = !idle;
  assign out_status = 2'(status);

  `TTI_ASSERT_NXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall)
  `TTI_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, cmd.out_ld, !out_valid || !out_stall)
  `TTI_ASSERT_IMP(a_one_entry_write, clk, rst_n, 1'b1, $onehot0({cmd.mark_wr, cmd.avg_wr, cmd.sh_wr, cmd.ins_wr}))
endmodule
`default_nettype wire
